FILE: hw/rtl/tre_pkg.sv
// Shared types and constants for the trend ratio evaluator.
// Holds the controller states, datapath operation codes and the command and status structs.
// No dependencies.
package tre_pkg;

  localparam int unsigned DivSteps  = 72;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned MulSteps  = 32;
  localparam int unsigned StepCntW  = 7;

  localparam logic [47:0] BaseReset = 48'd2560000000;
  localparam logic [63:0] TopBit    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosCap    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOPE_LOAD, ST_SLOPE_DIV, ST_SLOPE_FIN, ST_RES_INIT, ST_RES_RD, ST_RES_MUL,
    ST_RES_ERR, ST_RES_SQ, ST_RES_ACC, ST_MEAN_DIV, ST_SQRT, ST_TREND_SEL, ST_TREND_MUL,
    ST_TREND_DIV, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_SLOPE_LOAD, OP_DIV_STEP, OP_SLOPE_FIN, OP_RES_INIT, OP_RES_RD,
    OP_RES_MUL, OP_RES_ERR, OP_RES_SQ, OP_RES_ACC, OP_MEAN_LOAD, OP_SQRT_LOAD, OP_SQRT_STEP,
    OP_MUL_LOAD, OP_MUL_STEP, OP_TDIV_LOAD, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic slope_skip;
    logic idx_last;
    logic risk_zero;
    logic neg;
  } sts_t;

endpackage

FILE: hw/rtl/tre_ctrl.sv
// Sequencing state machine for the trend ratio evaluator.
// Depends on tre_pkg; drives tre_dp through cmd_t and reads sts_t.
module tre_ctrl import tre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic last_day_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q + StepCntW'(1);
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start) begin
          cmd_o.op = OP_TAKE;
          if (last_day_i) state_d = ST_SLOPE_LOAD;
        end
      end
      ST_SLOPE_LOAD: begin
        cmd_o.op = OP_SLOPE_LOAD;
        cnt_d    = '0;
        state_d  = sts_i.slope_skip ? ST_RES_INIT : ST_SLOPE_DIV;
      end
      ST_SLOPE_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == StepCntW'(DivSteps - 1)) state_d = ST_SLOPE_FIN;
      end
      ST_SLOPE_FIN: begin
        cmd_o.op = OP_SLOPE_FIN;
        state_d  = ST_RES_INIT;
      end
      ST_RES_INIT: begin
        cmd_o.op = OP_RES_INIT;
        state_d  = ST_RES_RD;
      end
      ST_RES_RD: begin
        cmd_o.op = OP_RES_RD;
        state_d  = ST_RES_MUL;
      end
      ST_RES_MUL: begin
        cmd_o.op = OP_RES_MUL;
        state_d  = ST_RES_ERR;
      end
      ST_RES_ERR: begin
        cmd_o.op = OP_RES_ERR;
        state_d  = ST_RES_SQ;
      end
      ST_RES_SQ: begin
        cmd_o.op = OP_RES_SQ;
        state_d  = ST_RES_ACC;
      end
      ST_RES_ACC: begin
        cmd_o.op = OP_RES_ACC;
        cnt_d    = '0;
        state_d  = sts_i.idx_last ? ST_MEAN_DIV : ST_RES_RD;
        // The mean division loads in its first cycle, once the last square is in the sum.
      end
      ST_MEAN_DIV: begin
        if (cnt_q == '0) begin
          cmd_o.op = OP_MEAN_LOAD;
        end else begin
          cmd_o.op = OP_DIV_STEP;
          if (cnt_q == StepCntW'(DivSteps)) state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_q == StepCntW'(DivSteps + 1)) begin
          cmd_o.op = OP_SQRT_LOAD;
          cnt_d    = '0;
        end else begin
          cmd_o.op = OP_SQRT_STEP;
          if (cnt_q == StepCntW'(SqrtSteps - 1)) state_d = ST_TREND_SEL;
        end
      end
      ST_TREND_SEL: begin
        cnt_d = '0;
        if (sts_i.risk_zero) begin
          state_d = ST_EMIT;
        end else if (sts_i.neg) begin
          cmd_o.op = OP_MUL_LOAD;
          state_d  = ST_TREND_MUL;
        end else begin
          cmd_o.op = OP_TDIV_LOAD;
          state_d  = ST_TREND_DIV;
        end
      end
      ST_TREND_MUL: begin
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == StepCntW'(MulSteps - 1)) state_d = ST_EMIT;
      end
      ST_TREND_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == StepCntW'(DivSteps - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op = OP_EMIT;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/tre_dp.sv
// Datapath of the trend ratio evaluator: value memory, accumulators, divider, root and multiplier.
// Depends on tre_pkg; driven by tre_ctrl through cmd_t.
module tre_dp import tre_pkg::*; #(
  parameter int unsigned MAX_DAYS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [47:0] fund_value_i,
  input  logic        empty_portfolio_i,
  input  logic        base_funds_we_i,
  input  logic [47:0] base_funds_i,
  output logic        done_o,
  output logic [63:0] slope_o,
  output logic [47:0] risk_level_o,
  output logic [63:0] trend_ratio_o,
  output logic        zero_risk_o,
  output logic [8:0]  days_seen_o
);

  localparam int unsigned KW = $clog2(MAX_DAYS + 1);
  localparam int unsigned AW = $clog2(MAX_DAYS);
  localparam int unsigned SW = 3 * KW;
  localparam int unsigned PW = 51 + KW;

  logic [47:0]        base_q;
  logic [KW-1:0]      day_q;
  logic signed [63:0] wsum_q;
  logic [SW-1:0]      sqsum_q;
  logic               empty_q;
  logic               valid_q;

  logic [47:0] mem [MAX_DAYS];
  logic [47:0] rd_q;
  logic [KW-1:0] idx_q;
  logic [63:0] mmag_q, pm_q, em_q, sq_q, rss_q, sv_q, root_q, rbit_q, den_q;
  logic        neg_q;
  logic [71:0] dvd_q;
  logic [63:0] rem_q;
  logic [95:0] mp_q;
  logic [63:0] slope_q, trend_q;
  logic [47:0] risk_q;
  logic        zr_q;
  logic [8:0]  days_q;

  // Day intake
  logic [KW-1:0]        k_in;
  logic signed [49:0]   dev;
  logic signed [PW-1:0] prod;
  logic signed [64:0]   wsum_nx;
  assign k_in    = day_q + KW'(1);
  assign dev     = $signed({2'b0, fund_value_i}) - $signed({2'b0, base_q});
  assign prod    = PW'(dev) * $signed(PW'({1'b0, k_in}));
  assign wsum_nx = 65'(wsum_q) + 65'(prod);

  // Residual pass
  logic [KW-1:0]      k_res;
  logic [63+KW:0]     pm_full;
  logic [63:0]        fofs;
  logic signed [63:0] d64, e64;
  logic [64:0]        rss_nx;
  assign k_res   = idx_q + KW'(1);
  assign pm_full = {{KW{1'b0}}, mmag_q} * {{64{1'b0}}, k_res};
  assign fofs    = (pm_q + 64'd128) >> 8;
  assign d64     = $signed({16'b0, rd_q}) - $signed({16'b0, base_q});
  assign e64     = neg_q ? d64 + $signed(fofs) : d64 - $signed(fofs);
  assign rss_nx  = {1'b0, rss_q} + {1'b0, sq_q};

  // Restoring divider step
  logic [64:0] trial;
  logic        qbit;
  assign trial = {rem_q, dvd_q[71]};
  assign qbit  = (trial >= {1'b0, den_q});

  // Root step
  logic [63:0] rtry;
  assign rtry = root_q + rbit_q;

  // Shift-add multiplier step
  logic [64:0] msum;
  assign msum = {1'b0, mp_q[95:32]} + ((mp_q[0]) ? {1'b0, mmag_q} : 65'd0);

  // Saturated results
  logic [63:0] slope_cap, slope_mag, tdiv_mag, tmul_mag, trend_mag;
  assign slope_cap = neg_q ? TopBit : PosCap;
  assign slope_mag = (dvd_q > {8'b0, slope_cap}) ? slope_cap : dvd_q[63:0];
  assign tdiv_mag  = (dvd_q > {8'b0, PosCap}) ? PosCap : dvd_q[63:0];
  assign tmul_mag  = (mp_q[95:72] != '0 || mp_q[71:8] > TopBit) ? TopBit : mp_q[71:8];
  assign trend_mag = neg_q ? tmul_mag : tdiv_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      day_q   <= '0;
      wsum_q  <= '0;
      sqsum_q <= '0;
      empty_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (base_funds_we_i) base_q <= base_funds_i;
      case (cmd_i.op)
        OP_TAKE: begin
          empty_q <= empty_portfolio_i;
          if (day_q < KW'(MAX_DAYS)) begin
            day_q   <= k_in;
            sqsum_q <= sqsum_q + SW'(k_in) * SW'(k_in);
            if (k_in >= KW'(2)) begin
              if (wsum_nx[64] != wsum_nx[63]) begin
                wsum_q <= wsum_nx[64] ? $signed(TopBit) : $signed(PosCap);
              end else begin
                wsum_q <= wsum_nx[63:0];
              end
            end
          end
        end
        OP_EMIT: begin
          valid_q <= 1'b1;
          day_q   <= '0;
          wsum_q  <= '0;
          sqsum_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_TAKE && day_q < KW'(MAX_DAYS)) mem[day_q[AW-1:0]] <= fund_value_i;
    if (cmd_i.op == OP_RES_RD) rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SLOPE_LOAD: begin
        mmag_q <= '0;
        neg_q  <= sts_o.slope_skip ? 1'b0 : wsum_q[63];
        dvd_q  <= {(wsum_q[63] ? 64'd0 - wsum_q : wsum_q), 8'd0};
        den_q  <= 64'(sqsum_q);
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= qbit ? 64'(trial - {1'b0, den_q}) : trial[63:0];
        dvd_q <= {dvd_q[70:0], qbit};
      end
      OP_SLOPE_FIN: begin
        mmag_q <= slope_mag;
        neg_q  <= neg_q && (slope_mag != '0);
      end
      OP_RES_INIT: begin
        idx_q <= '0;
        rss_q <= '0;
      end
      OP_RES_MUL: pm_q <= (pm_full > (64 + KW)'(TopBit)) ? TopBit : pm_full[63:0];
      OP_RES_ERR: em_q <= e64[63] ? 64'd0 - e64 : e64;
      OP_RES_SQ:  sq_q <= (em_q[63:32] != '0) ? '1 : em_q[31:0] * em_q[31:0];
      OP_RES_ACC: begin
        rss_q <= rss_nx[64] ? '1 : rss_nx[63:0];
        idx_q <= k_res;
      end
      OP_MEAN_LOAD: begin
        dvd_q <= {8'd0, rss_q};
        den_q <= 64'(day_q);
        rem_q <= '0;
      end
      OP_SQRT_LOAD: begin
        sv_q   <= dvd_q[63:0];
        root_q <= '0;
        rbit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= rtry) begin
          sv_q   <= sv_q - rtry;
          root_q <= (root_q >> 1) + rbit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
      end
      OP_MUL_LOAD: mp_q <= {64'd0, root_q[31:0]};
      OP_MUL_STEP: mp_q <= {msum, mp_q[31:1]};
      OP_TDIV_LOAD: begin
        dvd_q <= {mmag_q, 8'd0};
        den_q <= {32'd0, root_q[31:0]};
        rem_q <= '0;
      end
      OP_EMIT: begin
        slope_q <= neg_q ? 64'd0 - mmag_q : mmag_q;
        risk_q  <= root_q[47:0];
        zr_q    <= (root_q == '0);
        trend_q <= (root_q == '0) ? 64'd0 : (neg_q ? 64'd0 - trend_mag : trend_mag);
        days_q  <= 9'(day_q);
      end
      default: ;
    endcase
  end

  assign sts_o.slope_skip = empty_q || (sqsum_q == '0);
  assign sts_o.idx_last   = (idx_q == day_q - KW'(1));
  assign sts_o.risk_zero  = (root_q == '0);
  assign sts_o.neg        = neg_q;

  assign done_o        = valid_q;
  assign slope_o       = slope_q;
  assign risk_level_o  = risk_q;
  assign trend_ratio_o = trend_q;
  assign zero_risk_o   = zr_q;
  assign days_seen_o   = days_q;

endmodule

FILE: hw/rtl/trend_ratio_evaluator.sv
// Top level of the trend ratio evaluator: linear trend fit, RMS risk and trend ratio.
// Depends on tre_pkg, tre_ctrl and tre_dp.
//
//   Channel   Signals                                         Handshake
//   request   fund_value_i, last_day_i, empty_portfolio_i     start && !busy
//   result    slope_o .. days_seen_o                          done_o, one cycle
//   config    base_funds_i                                    base_funds_we_i
//
// A day that is not the last does not raise busy, and the next request may follow at once.
// After the last day, busy stays high through the slope division (load, division steps,
// finish), the residual pass (an init step, then read, multiply, error, square and
// accumulate for each stored day), the mean division, the square root, the select, the
// trend division and the emit. A falling trend uses the shift-add multiply instead, zero
// risk skips both, and a skipped slope saves the slope division. The result strobe rises in
// the same cycle that busy drops and is not stalled by the receiver. Reset clears the counters
// and sets base_funds to 10000000.0.
module trend_ratio_evaluator import tre_pkg::*; #(
  parameter int unsigned MAX_DAYS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] fund_value_i,
  input  logic        last_day_i,
  input  logic        empty_portfolio_i,
  input  logic        base_funds_we_i,
  input  logic [47:0] base_funds_i,
  output logic        done_o,
  output logic [63:0] slope_o,
  output logic [47:0] risk_level_o,
  output logic [63:0] trend_ratio_o,
  output logic        zero_risk_o,
  output logic [8:0]  days_seen_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences every step; the datapath holds all values.
  tre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .last_day_i (last_day_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  tre_dp #(.MAX_DAYS(MAX_DAYS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .fund_value_i      (fund_value_i),
    .empty_portfolio_i (empty_portfolio_i),
    .base_funds_we_i   (base_funds_we_i),
    .base_funds_i      (base_funds_i),
    .done_o            (done_o),
    .slope_o           (slope_o),
    .risk_level_o      (risk_level_o),
    .trend_ratio_o     (trend_ratio_o),
    .zero_risk_o       (zero_risk_o),
    .days_seen_o       (days_seen_o)
  );

  // The result strobe lasts one cycle and the block is free again while it shows.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy while result shown");
  a_plain_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_day_i) |=> (!busy && !done_o))
    else $error("ordinary day did not complete in one cycle");
  a_zero_risk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_risk_o) |-> (trend_ratio_o == '0 && risk_level_o == '0))
    else $error("zero risk with nonzero trend");

endmodule
